@@ rtl/fslm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fslm_pkg
// Shared types, constants and helpers for the frame stage latency monitor.
// ----------------------------------------------------------------------------
package fslm_pkg;

  localparam int RING_ENTRIES_DEF = 256;
  localparam int NUM_STAGES       = 5;
  localparam int ID_W             = 32;
  localparam int TS_W             = 48;
  localparam int DLT_W            = 32;
  localparam int ACT_W            = 3;
  localparam int COUNT_OUT_W      = 9;
  localparam int IN_TDATA_W       = 80;
  localparam int OUT_TDATA_W      = 336;

  typedef enum logic [ACT_W-1:0] {
    ACT_CAPTURE = 3'd0,
    ACT_DECODE  = 3'd1,
    ACT_FILTER  = 3'd2,
    ACT_ENCODE  = 3'd3,
    ACT_SEND    = 3'd4,
    ACT_QUERY   = 3'd5,
    ACT_CLEAR   = 3'd6,
    ACT_RSVD    = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_SWEEP,
    B_IDLE,
    B_EV_WR,
    B_WALK,
    B_DRAIN,
    B_DIV_GO,
    B_DIV_WAIT,
    B_OUT
  } back_state_t;

  // modulo 2^48 difference, saturated to 32 bits
  function automatic logic [DLT_W-1:0] delta_sat(input logic [TS_W-1:0] later,
                                                 input logic [TS_W-1:0] earlier);
    logic [TS_W-1:0] d;
    d = later - earlier;
    return (|d[TS_W-1:DLT_W]) ? '1 : d[DLT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/frame_stage_latency_monitor_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frame_stage_latency_monitor_top
// Per-frame stage timestamp ring with latency statistics on request.
//
// s_*: one event word per handshake; tuser is the action, tdata carries
// id and timestamp. Capture and stage events write the ring slot of
// the frame; clear empties the ring; a query returns one statistics word
// on m_*.
// An event is handled in the back end by a slot read, then a write; when the
// ring size is not a power of two, the front end first reduces the id to a
// slot by reciprocal multiplication. A query walks min(last id + 1,
// RING_ENTRIES) slots at one per cycle, then, if any frame was counted, runs
// five serial divisions. After reset, and after a clear, the ring is swept
// with s_tready low. A stalled m_tready holds the result word; the front end
// and a two-word queue keep taking events meanwhile, until the queue is full.
// ----------------------------------------------------------------------------
module frame_stage_latency_monitor_top #(
  parameter int RING_ENTRIES = fslm_pkg::RING_ENTRIES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [fslm_pkg::ACT_W-1:0]           s_tuser,  // action
  input  wire logic [fslm_pkg::IN_TDATA_W-1:0]      s_tdata,  // id, timestamp_us
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // frames counted, avg_decode/filter/encode/send_us, max_decode/filter/encode/send_us,
  // e2e_avg_us, e2e_max_us, zero pad
  output logic      [fslm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int IDX_W = $clog2(RING_ENTRIES);
  localparam int Q_W   = IDX_W + fslm_pkg::TS_W + fslm_pkg::ID_W + fslm_pkg::ACT_W;

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  logic [Q_W-1:0] q_in;
  logic [Q_W-1:0] q_head;
  logic           sweeping;

  fslm_front #(.RING_ENTRIES(RING_ENTRIES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .sweeping (sweeping),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  fslm_fifo #(.WIDTH(Q_W)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  fslm_back #(.RING_ENTRIES(RING_ENTRIES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_head),
    .q_pop    (q_pop),
    .sweeping (sweeping),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef ASSERT_OFF
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !s_tready)
    else $error("word accepted during ring sweep");

  a_e2e_avg_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[328:297] >= m_tdata[296:265]))
    else $error("end-to-end average above maximum");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire

@@ rtl/fslm_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fslm_fifo
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module fslm_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  assign head  = mem[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule
`default_nettype wire

@@ rtl/fslm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fslm_front
// Accepts input words, tracks the last captured id, works out the ring slot
// and the query window, and queues the decoded operation.
// ----------------------------------------------------------------------------
module fslm_front #(
  parameter int RING_ENTRIES = fslm_pkg::RING_ENTRIES_DEF,
  localparam int IDX_W = $clog2(RING_ENTRIES),
  localparam int CNT_W = $clog2(RING_ENTRIES + 1),
  localparam int Q_W   = IDX_W + fslm_pkg::TS_W + fslm_pkg::ID_W + fslm_pkg::ACT_W
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [fslm_pkg::ACT_W-1:0]          s_tuser,
  input  wire logic [fslm_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  wire logic                                sweeping,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output logic      [Q_W-1:0]                      q_data
);

  localparam bit POW2 = (RING_ENTRIES & (RING_ENTRIES - 1)) == 0;
  localparam int MAG_SH = fslm_pkg::ID_W + IDX_W;
  localparam longint unsigned MAGIC =
    ((64'd1 << MAG_SH) + 64'(RING_ENTRIES) - 64'd1) / 64'(RING_ENTRIES);

  fslm_pkg::front_state_t fstate, fstate_next;
  logic [fslm_pkg::ACT_W-1:0] act;
  logic [fslm_pkg::ID_W-1:0]  id;
  logic [fslm_pkg::TS_W-1:0]  ts;
  logic [fslm_pkg::ID_W-1:0]  red;
  logic [fslm_pkg::ID_W:0]    magic;
  logic [2*fslm_pkg::ID_W:0]  prod;
  logic [fslm_pkg::ID_W-1:0]  quo;
  logic [fslm_pkg::ID_W-1:0]  diff;
  logic [IDX_W-1:0]           rem;
  logic                       div_step;
  logic [fslm_pkg::ID_W-1:0]  last;
  logic [fslm_pkg::ID_W:0]    last1;
  logic [CNT_W-1:0]           samples;
  logic [fslm_pkg::ID_W-1:0]  start;
  logic [IDX_W-1:0]           slot;
  logic                       accept;
  logic                       in_act_ok;

  assign accept    = s_tvalid && s_tready;
  assign in_act_ok = (s_tuser != fslm_pkg::ACT_RSVD);
  assign last1     = {1'b0, last} + 33'd1;
  assign samples   = (last1 > 33'(RING_ENTRIES)) ? CNT_W'(RING_ENTRIES)
                                                 : last1[CNT_W-1:0];
  assign start     = last1[fslm_pkg::ID_W-1:0] - fslm_pkg::ID_W'(samples);
  // slot by reciprocal multiplication: quotient, then remainder
  assign magic     = (fslm_pkg::ID_W+1)'(MAGIC);
  assign prod      = {33'd0, red} * {32'd0, magic};
  assign diff      = red - quo * fslm_pkg::ID_W'(RING_ENTRIES);
  assign slot      = POW2 ? red[IDX_W-1:0] : rem;

  always_comb begin
    fstate_next = fstate;
    unique case (fstate)
      fslm_pkg::F_IDLE: begin
        if (accept && in_act_ok) fstate_next = POW2 ? fslm_pkg::F_PUSH : fslm_pkg::F_DIV;
      end
      fslm_pkg::F_DIV: begin
        if (div_step) fstate_next = fslm_pkg::F_PUSH;
      end
      fslm_pkg::F_PUSH: begin
        if (!q_full) fstate_next = fslm_pkg::F_IDLE;
      end
      default: fstate_next = fslm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (fstate == fslm_pkg::F_IDLE) && !sweeping;
    q_push   = (fstate == fslm_pkg::F_PUSH) && !q_full;
    q_data   = {slot, ts, id, act};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate   <= fslm_pkg::F_IDLE;
      last     <= '0;
      div_step <= 1'b0;
    end else begin
      fstate <= fstate_next;
      if (accept && in_act_ok) begin
        div_step <= 1'b0;
        if (s_tuser == fslm_pkg::ACT_CAPTURE) last <= s_tdata[31:0];
        else if (s_tuser == fslm_pkg::ACT_CLEAR) last <= '0;
      end else if (fstate == fslm_pkg::F_DIV) begin
        div_step <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= s_tuser;
      if (s_tuser == fslm_pkg::ACT_QUERY) begin
        id  <= start;
        ts  <= fslm_pkg::TS_W'(samples);
        red <= start;
      end else begin
        id  <= s_tdata[31:0];
        ts  <= s_tdata[79:32];
        red <= s_tdata[31:0];
      end
    end else if (fstate == fslm_pkg::F_DIV) begin
      if (!div_step) quo <= fslm_pkg::ID_W'(prod >> MAG_SH);
      else rem <= diff[IDX_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/fslm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fslm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fslm_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W:0]    trial;
  logic [STEP_W-1:0] steps;
  logic              busy;

  assign trial    = {rem, dvd[DVD_W-1]};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dvs   <= divisor;
      rem   <= '0;
      steps <= '0;
    end else if (busy) begin
      steps <= steps + STEP_W'(1);
      if (trial >= {1'b0, dvs}) begin
        rem <= DVS_W'(trial - {1'b0, dvs});
        dvd <= {dvd[DVD_W-2:0], 1'b1};
      end else begin
        rem <= trial[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fslm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fslm_back
// Executes queued operations on the ring memories: slot updates, the clear sweep,
// the query walk with its delta pipeline, averaging and the result register.
// ----------------------------------------------------------------------------
module fslm_back #(
  parameter int RING_ENTRIES = fslm_pkg::RING_ENTRIES_DEF,
  localparam int IDX_W = $clog2(RING_ENTRIES),
  localparam int CNT_W = $clog2(RING_ENTRIES + 1),
  localparam int Q_W   = IDX_W + fslm_pkg::TS_W + fslm_pkg::ID_W + fslm_pkg::ACT_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_empty,
  input  wire logic [Q_W-1:0]                   q_data,
  output logic                                  q_pop,
  output logic                                  sweeping,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [fslm_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int NS    = fslm_pkg::NUM_STAGES;
  localparam int SUM_W = fslm_pkg::DLT_W + CNT_W;
  localparam int DW    = fslm_pkg::DLT_W;
  localparam int TW    = fslm_pkg::TS_W;

  fslm_pkg::back_state_t bstate, bstate_next;

  logic [fslm_pkg::ID_W-1:0] fmem [RING_ENTRIES];
  logic [NS-1:0]             smem [RING_ENTRIES];
  logic [TW-1:0]             tmem [NS][RING_ENTRIES];

  fslm_pkg::action_t          h_act;
  logic [fslm_pkg::ID_W-1:0]  h_id;
  logic [TW-1:0]              h_ts;
  logic [IDX_W-1:0]           h_slot;

  fslm_pkg::action_t          act;
  logic [fslm_pkg::ID_W-1:0]  id;
  logic [TW-1:0]              ts;
  logic [IDX_W-1:0]           slot;

  logic [IDX_W-1:0]           raddr;
  logic [fslm_pkg::ID_W-1:0]  rd_frame;
  logic [NS-1:0]              rd_seen;
  logic [TW-1:0]              rd_t [NS];

  logic                       fwe;
  logic [fslm_pkg::ID_W-1:0]  fdata;
  logic                       swe;
  logic [NS-1:0]              sdata;
  logic                       twe;
  logic [2:0]                 tbank;
  logic [IDX_W-1:0]           waddr;
  logic [NS-1:0]              stage_bit;

  logic [IDX_W-1:0]           sweep_addr;
  logic [IDX_W-1:0]           walk_slot;
  logic [fslm_pkg::ID_W-1:0]  walk_fid;
  logic [CNT_W-1:0]           walk_left;

  logic                       p1_v;
  logic [fslm_pkg::ID_W-1:0]  p1_fid;
  logic [DW-1:0]              c_d  [NS];
  logic [NS-1:0]              c_dv;
  logic [TW-1:0]              prv;
  logic                       hp;
  logic                       p2_v;
  logic [DW-1:0]              p2_d [NS];
  logic [NS-1:0]              p2_dv;

  logic [SUM_W-1:0]           sum  [NS];
  logic [DW-1:0]              mx   [NS];
  logic [DW-1:0]              avg  [NS];
  logic [CNT_W-1:0]           count;
  logic [2:0]                 div_k;
  logic                       div_start;
  logic                       div_done;
  logic [SUM_W-1:0]           div_q;
  logic                       load;

  assign h_act  = fslm_pkg::action_t'(q_data[2:0]);
  assign h_id   = q_data[34:3];
  assign h_ts   = q_data[82:35];
  assign h_slot = q_data[Q_W-1:83];
  assign stage_bit = NS'(1) << act;

  // next state
  always_comb begin
    bstate_next = bstate;
    unique case (bstate)
      fslm_pkg::B_SWEEP:
        if (sweep_addr == IDX_W'(RING_ENTRIES - 1)) bstate_next = fslm_pkg::B_IDLE;
      fslm_pkg::B_IDLE:
        if (!q_empty) begin
          unique case (h_act)
            fslm_pkg::ACT_QUERY: bstate_next = fslm_pkg::B_WALK;
            fslm_pkg::ACT_CLEAR: bstate_next = fslm_pkg::B_SWEEP;
            default:             bstate_next = fslm_pkg::B_EV_WR;
          endcase
        end
      fslm_pkg::B_EV_WR: bstate_next = fslm_pkg::B_IDLE;
      fslm_pkg::B_WALK:
        if (walk_left == CNT_W'(1)) bstate_next = fslm_pkg::B_DRAIN;
      fslm_pkg::B_DRAIN:
        if (!p1_v && !p2_v)
          bstate_next = (count == '0) ? fslm_pkg::B_OUT : fslm_pkg::B_DIV_GO;
      fslm_pkg::B_DIV_GO: bstate_next = fslm_pkg::B_DIV_WAIT;
      fslm_pkg::B_DIV_WAIT:
        if (div_done) bstate_next = (div_k == 3'd4) ? fslm_pkg::B_OUT : fslm_pkg::B_DIV_GO;
      fslm_pkg::B_OUT:
        if (!m_tvalid || m_tready) bstate_next = fslm_pkg::B_IDLE;
      default: bstate_next = fslm_pkg::B_IDLE;
    endcase
  end

  // outputs and memory write control
  always_comb begin
    q_pop     = (bstate == fslm_pkg::B_IDLE) && !q_empty;
    sweeping  = (bstate == fslm_pkg::B_SWEEP);
    div_start = (bstate == fslm_pkg::B_DIV_GO);
    load      = (bstate == fslm_pkg::B_OUT) && (!m_tvalid || m_tready);
    raddr     = (bstate == fslm_pkg::B_IDLE) ? h_slot : walk_slot;
    fwe   = 1'b0;
    swe   = 1'b0;
    twe   = 1'b0;
    fdata = '0;
    sdata = '0;
    tbank = 3'd0;
    waddr = slot;
    if (bstate == fslm_pkg::B_SWEEP) begin
      fwe   = 1'b1;
      swe   = 1'b1;
      waddr = sweep_addr;
    end else if (bstate == fslm_pkg::B_EV_WR) begin
      if (act == fslm_pkg::ACT_CAPTURE) begin
        fwe   = 1'b1;
        fdata = id;
        swe   = 1'b1;
        sdata = NS'(1);
        twe   = 1'b1;
      end else if (rd_frame == id || (rd_seen & stage_bit) == '0) begin
        swe   = 1'b1;
        sdata = rd_seen | stage_bit;
        twe   = 1'b1;
        tbank = act;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fwe) fmem[waddr] <= fdata;
    if (swe) smem[waddr] <= sdata;
    if (twe) tmem[tbank][waddr] <= ts;
  end

  always_ff @(posedge clk) begin
    rd_frame <= fmem[raddr];
    rd_seen  <= smem[raddr];
    for (int b = 0; b < NS; b++) rd_t[b] <= tmem[b][raddr];
  end

  // deltas of one walked slot; index 0 holds capture-to-send
  always_comb begin
    prv  = '0;
    hp   = 1'b0;
    c_dv = '0;
    for (int s = 0; s < NS; s++) c_d[s] = '0;
    for (int s = 0; s < NS; s++) begin
      if (rd_seen[s]) begin
        if (hp) begin
          c_d[s]  = fslm_pkg::delta_sat(rd_t[s], prv);
          c_dv[s] = 1'b1;
        end
        prv = rd_t[s];
        hp  = 1'b1;
      end
    end
    if (rd_seen[0] && rd_seen[NS-1]) begin
      c_d[0]  = fslm_pkg::delta_sat(rd_t[NS-1], rd_t[0]);
      c_dv[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate     <= fslm_pkg::B_SWEEP;
      sweep_addr <= '0;
      p1_v       <= 1'b0;
      p2_v       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      bstate <= bstate_next;
      p1_v   <= (bstate == fslm_pkg::B_WALK);
      p2_v   <= p1_v && (rd_frame == p1_fid);
      if (bstate == fslm_pkg::B_SWEEP) sweep_addr <= sweep_addr + IDX_W'(1);
      else sweep_addr <= '0;
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    p1_fid <= walk_fid;
    p2_d   <= c_d;
    p2_dv  <= c_dv;
    if (q_pop) begin
      act  <= h_act;
      id   <= h_id;
      ts   <= h_ts;
      slot <= h_slot;
      walk_slot <= h_slot;
      walk_fid  <= h_id;
      walk_left <= h_ts[CNT_W-1:0];
      count <= '0;
      div_k <= 3'd0;
      for (int s = 0; s < NS; s++) begin
        sum[s] <= '0;
        mx[s]  <= '0;
        avg[s] <= '0;
      end
    end else begin
      if (bstate == fslm_pkg::B_WALK) begin
        walk_slot <= (walk_slot == IDX_W'(RING_ENTRIES - 1)) ? '0 : walk_slot + IDX_W'(1);
        walk_fid  <= walk_fid + fslm_pkg::ID_W'(1);
        walk_left <= walk_left - CNT_W'(1);
      end
      if (p2_v) begin
        for (int s = 0; s < NS; s++) begin
          if (p2_dv[s]) begin
            sum[s] <= sum[s] + SUM_W'(p2_d[s]);
            if (p2_d[s] > mx[s]) mx[s] <= p2_d[s];
          end
        end
        if (p2_dv[0]) count <= count + CNT_W'(1);
      end
      if (div_done) begin
        avg[(div_k == 3'd4) ? 3'd0 : div_k + 3'd1] <=
          (|div_q[SUM_W-1:DW]) ? '1 : div_q[DW-1:0];
        div_k <= div_k + 3'd1;
      end
    end
    // empty window gives an all-zero word
    if (load) begin
      m_tdata <= (count == '0) ? '0 :
                 {7'd0, mx[0], avg[0], mx[4], mx[3], mx[2], mx[1],
                  avg[4], avg[3], avg[2], avg[1], fslm_pkg::COUNT_OUT_W'(count)};
    end
  end

  fslm_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ((div_k == 3'd4) ? sum[0] : sum[div_k + 3'd1]),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
`default_nettype wire
